FILE: rtl/acrp_pkg.sv
package acrp_pkg;

    localparam int SLOT_W        = 32;
    localparam int TOTAL_W       = 36;
    localparam int CNT_W         = 5;
    localparam int OP_W          = 2;
    localparam int MAX_SLOTS_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_CONSUME = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // result of one pass through the shared slot unit
    typedef struct packed {
        logic [SLOT_W-1:0] slot_new;
        logic [SLOT_W-1:0] demand_new;
        logic [SLOT_W-1:0] delta;
        logic              grow;
    } alu_res_t;

endpackage

FILE: rtl/acrp_cmd_if.sv
interface acrp_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [acrp_pkg::OP_W-1:0]    operation;
    logic [acrp_pkg::SLOT_W-1:0]  amount;

    modport source (output valid, output operation, output amount, input ready);
    modport sink (input valid, input operation, input amount, output ready);
endinterface

FILE: rtl/acrp_res_if.sv
interface acrp_res_if;
    logic                          valid;
    logic                          ready;
    logic [acrp_pkg::SLOT_W-1:0]   unmet;
    logic [acrp_pkg::TOTAL_W-1:0]  pool_total;

    modport source (output valid, output unmet, output pool_total, input ready);
    modport sink (input valid, input unmet, input pool_total, output ready);
endinterface

FILE: rtl/acrp_slot_mem.sv
module acrp_slot_mem #(
    parameter int DEPTH = acrp_pkg::MAX_SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         we,
    input  logic [AW-1:0]                wr_addr,
    input  logic [acrp_pkg::SLOT_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [acrp_pkg::SLOT_W-1:0]  rd_data
);

    logic [acrp_pkg::SLOT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [acrp_pkg::SLOT_W-1:0] rd_q_reg;
    logic                        rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // an entry never written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr] && !(clear);
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

FILE: rtl/acrp_alu.sv
module acrp_alu (
    input  acrp_pkg::op_t                op,
    input  logic [acrp_pkg::SLOT_W-1:0]  amount,
    input  logic [acrp_pkg::SLOT_W-1:0]  slot,
    output acrp_pkg::alu_res_t           res
);

    logic [acrp_pkg::SLOT_W-1:0] room;
    logic [acrp_pkg::SLOT_W-1:0] take;

    always_comb
    begin
        room = ~slot;
        take = (amount < room) ? amount : room;
        res.slot_new   = slot;
        res.demand_new = amount;
        res.delta      = '0;
        res.grow       = 1'b0;
        unique case (op)
            acrp_pkg::OP_ADD:
            begin
                // saturate the slot at its maximum
                res.slot_new = slot + take;
                res.delta    = take;
                res.grow     = 1'b1;
            end
            acrp_pkg::OP_CONSUME:
            begin
                if (slot >= amount)
                begin
                    res.slot_new   = slot - amount;
                    res.demand_new = '0;
                    res.delta      = amount;
                end
                else
                begin
                    res.slot_new   = '0;
                    res.demand_new = amount - slot;
                    res.delta      = slot;
                end
            end
            acrp_pkg::OP_TICK:
            begin
                res.slot_new = '0;
                res.delta    = slot;
            end
            default:
            begin
                res.slot_new = slot;
            end
        endcase
    end

endmodule

FILE: rtl/aging_credit_ring_pool.sv
// flow: a request is accepted in S_IDLE; add and tick then pass through S_EXEC and
// S_DONE, a no-op and a consume of zero or from an empty pool go straight to S_DONE,
// and a consume stays in S_EXEC for each slot it visits (at most slot_count slots),
// one slot per cycle through the single slot unit; the result is registered from S_DONE,
// and a result still waiting at the output holds off the next request
// reset: store, pointer and total cleared, slot_count = min(MAX_SLOTS, 16); a write empties the pool
module aging_credit_ring_pool #(
    parameter int MAX_SLOTS = acrp_pkg::MAX_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [acrp_pkg::CNT_W-1:0]  cfg_data,
    acrp_cmd_if.sink                    cmd,
    acrp_res_if.source                  res
);

    localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = acrp_pkg::CNT_W;
    localparam logic [CNT_W-1:0] COUNT_RST =
        (MAX_SLOTS < 16) ? CNT_W'(MAX_SLOTS) : CNT_W'(16);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t                         state_reg;
    acrp_pkg::op_t                  op_reg;
    logic [acrp_pkg::SLOT_W-1:0]    demand_reg;
    logic [AW-1:0]                  pos_reg;
    logic [AW-1:0]                  cur_reg;
    logic [CNT_W-1:0]               k_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [acrp_pkg::TOTAL_W-1:0]   total_reg;
    logic [acrp_pkg::SLOT_W-1:0]    unmet_reg;
    logic                           out_valid_reg;
    logic [acrp_pkg::SLOT_W-1:0]    out_unmet_reg;
    logic [acrp_pkg::TOTAL_W-1:0]   out_total_reg;

    acrp_pkg::op_t                  cmd_op;
    logic                           accept;
    logic [AW-1:0]                  cur_back;
    logic [AW-1:0]                  pos_back;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [acrp_pkg::SLOT_W-1:0]    rd_data;
    acrp_pkg::alu_res_t             alu_res;
    logic [acrp_pkg::TOTAL_W-1:0]   total_next;
    logic                           cont;
    logic [CNT_W-1:0]               cfg_count;

    function automatic logic [AW-1:0] step_back(
        input logic [AW-1:0]    p,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W-1:0] last;
        last = n - CNT_W'(1);
        return (p == '0) ? AW'(last) : p - AW'(1);
    endfunction

    assign cmd_op   = acrp_pkg::op_t'(cmd.operation);
    assign accept   = cmd.valid && cmd.ready;
    assign cur_back = step_back(cur_reg, count_reg);
    assign pos_back = step_back(pos_reg, count_reg);

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_en   = accept;
            rd_addr = (cmd_op == acrp_pkg::OP_ADD) ? cur_reg : cur_back;
        end
        else
        begin
            rd_en   = (state_reg == S_EXEC);
            rd_addr = pos_back;
        end
    end

    always_comb
    begin
        cfg_count = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_count = CNT_W'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_SLOTS))
        begin
            cfg_count = CNT_W'(MAX_SLOTS);
        end
    end

    acrp_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_we),
        .we      (state_reg == S_EXEC),
        .wr_addr (pos_reg),
        .wr_data (alu_res.slot_new),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    acrp_alu u_alu (
        .op     (op_reg),
        .amount (demand_reg),
        .slot   (rd_data),
        .res    (alu_res)
    );

    assign total_next = alu_res.grow
        ? total_reg + acrp_pkg::TOTAL_W'(alu_res.delta)
        : total_reg - acrp_pkg::TOTAL_W'(alu_res.delta);

    // keep draining older slots while demand, credit and unvisited slots in the window remain
    assign cont = (op_reg == acrp_pkg::OP_CONSUME) && (k_reg < count_reg)
                  && (total_next != '0) && (alu_res.demand_new != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= acrp_pkg::OP_NONE;
            demand_reg    <= '0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            k_reg         <= '0;
            count_reg     <= COUNT_RST;
            total_reg     <= '0;
            unmet_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_unmet_reg <= '0;
            out_total_reg <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || res.ready))
            begin
                out_valid_reg <= 1'b1;
                out_unmet_reg <= unmet_reg;
                out_total_reg <= total_reg;
            end
            else if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= cmd_op;
                        demand_reg <= cmd.amount;
                        k_reg      <= CNT_W'(1);
                        unique case (cmd_op)
                            acrp_pkg::OP_ADD:
                            begin
                                pos_reg   <= cur_reg;
                                state_reg <= S_EXEC;
                            end
                            acrp_pkg::OP_TICK:
                            begin
                                pos_reg   <= cur_back;
                                cur_reg   <= cur_back;
                                state_reg <= S_EXEC;
                            end
                            acrp_pkg::OP_CONSUME:
                            begin
                                pos_reg <= cur_back;
                                if (total_reg == '0 || cmd.amount == '0)
                                begin
                                    unmet_reg <= cmd.amount;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_EXEC;
                                end
                            end
                            default:
                            begin
                                unmet_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_EXEC:
                begin
                    if (cont)
                    begin
                        pos_reg    <= pos_back;
                        demand_reg <= alu_res.demand_new;
                        k_reg      <= k_reg + CNT_W'(1);
                    end
                    else
                    begin
                        unmet_reg <= (op_reg == acrp_pkg::OP_CONSUME)
                                     ? alu_res.demand_new : '0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // window change restarts the pool empty
            if (cfg_we)
            begin
                count_reg <= cfg_count;
                cur_reg   <= '0;
                total_reg <= '0;
            end
            else if (state_reg == S_EXEC)
            begin
                total_reg <= total_next;
            end
        end
    end

    assign cmd.ready      = (state_reg == S_IDLE) && !cfg_we;
    assign res.valid      = out_valid_reg;
    assign res.unmet      = out_unmet_reg;
    assign res.pool_total = out_total_reg;

    a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_reg) < 32'(count_reg))
        else $error("pointer outside slot window");

    a_visit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (k_reg != '0 && k_reg <= count_reg))
        else $error("consume visited more slots than the window holds");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result produced outside the done step");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (total_reg == '0 && cur_reg == '0))
        else $error("window change did not empty the pool");

endmodule
